[hdl/ictf_pkg.sv]
// Package: shared types and constants for the complementary tilt filter.
package ictf_pkg;

    localparam int unsigned NUM_ATAN = 24;

    // arctangent of 2^-i in units of 2^-24 degree
    localparam logic [31:0] ATAN_DEG24 [NUM_ATAN] = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
        32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
        32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671,
        32'd29335, 32'd14668, 32'd7334, 32'd3667, 32'd1833,
        32'd917, 32'd458, 32'd229, 32'd115
    };

    localparam logic signed [33:0] NINETY_UNITS24 = 34'sd1509949440;

    localparam logic [0:0] REG_BLEND_WEIGHT = 1'b0;
    localparam logic [0:0] REG_RATE_GAIN    = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RATE,
        S_SQ,
        S_SQRT,
        S_CORDIC,
        S_ROUND,
        S_BLEND_A,
        S_BLEND_B,
        S_BLEND_C,
        S_NEXT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
    } t_in_item;

    typedef struct packed {
        logic signed [23:0] accel_roll;
        logic signed [23:0] accel_pitch;
        logic signed [31:0] fused_roll;
        logic signed [31:0] fused_pitch;
        logic signed [31:0] fused_yaw;
        logic signed [31:0] gyro_only_roll;
        logic signed [31:0] gyro_only_pitch;
        logic signed [31:0] gyro_only_yaw;
    } t_out_item;

    typedef struct packed {
        logic        index;
        logic [23:0] data;
    } t_cfg_item;

endpackage

[hdl/ictf_if.sv]
// Interface: valid/ready channel carrying one payload item.
interface ictf_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/imu_complementary_tilt_filter_core.sv]
// Top level: iterative complementary tilt filter for one accel/gyro sample per item.
// Each item is worked by a small sequencer: three rate products, then per tilt axis a
// squared sum, a restoring square root of 32 digit steps plus a load cycle, CORDIC_STEPS
// CORDIC iterations (at most 24), rounding, three blend steps and an update step. A new
// item is accepted only when the sequencer is idle; an axis with a zero numerator skips both
// the square root and CORDIC loops. The result item waits in an output register, so the
// next item may start while it is held; that next result waits until the previous one has
// been taken. Write configuration only between items: a write takes effect at once and would
// change an item in progress.
module imu_complementary_tilt_filter_core
    import ictf_pkg::*;
#(
    parameter int unsigned ANGLE_FRAC_BITS = 16,
    parameter int unsigned CORDIC_STEPS    = 18
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ictf_if.sink   s_in,
    ictf_if.source m_out,
    ictf_if.sink   s_cfg
);

    localparam int unsigned RSH  = 32 - ANGLE_FRAC_BITS;
    localparam int unsigned ZSH  = 24 - ANGLE_FRAC_BITS;
    localparam logic signed [33:0] LIM = 34'sd90 <<< ANGLE_FRAC_BITS;
    localparam int unsigned CW   = $clog2(NUM_ATAN);

    t_state r_state, n_state;

    logic [16:0] r_blend_weight;
    logic [23:0] r_rate_gain;

    t_in_item    r_in;
    logic [5:0]  r_cnt;
    logic        r_axis;   // 0 roll, 1 pitch
    logic [1:0]  r_rsel;

    logic signed [31:0] r_inc [3];   // pitch(x), roll(y), yaw(z)
    logic signed [31:0] r_est_roll, r_est_pitch, r_est_yaw;
    logic signed [31:0] r_int_roll, r_int_pitch, r_int_yaw;
    logic signed [23:0] r_tilt [2];

    // square root state
    logic [33:0] r_root;
    logic [63:0] r_sq;
    // cordic state
    logic signed [51:0] r_x, r_y;
    logic signed [33:0] r_z;
    logic [CW-1:0]      r_ci;
    logic               r_zero;
    // blend accumulator
    logic signed [63:0] r_acc;

    t_out_item r_out;
    logic      r_out_valid;

    assign s_cfg.ready = 1'b1;
    assign s_in.ready  = (r_state == S_IDLE);
    assign m_out.valid = r_out_valid;
    assign m_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_weight <= 17'd62915;
            r_rate_gain    <= 24'd163930;
        end else if (s_cfg.valid) begin
            unique case (s_cfg.data.index)
                REG_BLEND_WEIGHT: r_blend_weight <= s_cfg.data.data[16:0];
                REG_RATE_GAIN:    r_rate_gain    <= s_cfg.data.data;
                default: ;
            endcase
        end
    end

    // operands of the current axis
    logic signed [16:0] w_num, w_b, w_c;
    always_comb begin
        if (!r_axis) begin
            w_num = -17'(r_in.accel_x);
            w_b   = 17'(r_in.accel_y);
        end else begin
            w_num = 17'(r_in.accel_y);
            w_b   = 17'(r_in.accel_x);
        end
        w_c = 17'(r_in.accel_z);
    end

    logic signed [15:0] w_rate;
    always_comb begin
        case (r_rsel)
            2'd0:    w_rate = r_in.rate_x;
            2'd1:    w_rate = r_in.rate_y;
            default: w_rate = r_in.rate_z;
        endcase
    end

    logic signed [40:0] w_rprod;
    logic signed [40:0] w_rinc;
    assign w_rprod = 41'(w_rate) * $signed({1'b0, r_rate_gain});
    assign w_rinc  = (w_rprod + (41'sd1 <<< (RSH - 1))) >>> RSH;

    // cordic step
    logic signed [51:0] w_dx, w_dy;
    assign w_dx = r_y >>> r_ci;
    assign w_dy = r_x >>> r_ci;
    logic [31:0] w_atan;
    assign w_atan = ATAN_DEG24[r_ci];

    logic signed [33:0] w_zc, w_zr;
    always_comb begin
        w_zc = r_z;
        if (w_zc > NINETY_UNITS24)  w_zc = NINETY_UNITS24;
        if (w_zc < -NINETY_UNITS24) w_zc = -NINETY_UNITS24;
        w_zr = (w_zc + (34'sd1 <<< (ZSH - 1))) >>> ZSH;
        if (w_zr > LIM)  w_zr = LIM;
        if (w_zr < -LIM) w_zr = -LIM;
    end

    logic signed [17:0] w_alpha;
    assign w_alpha = (r_blend_weight > 17'd65536) ? 18'sd65536 : $signed({1'b0, r_blend_weight});
    logic signed [31:0] w_est;
    logic signed [31:0] w_einc;
    assign w_est  = r_axis ? r_est_pitch : r_est_roll;
    assign w_einc = r_axis ? r_inc[0] : r_inc[1];
    logic signed [32:0] w_e;
    assign w_e = 33'(w_est) + 33'(w_einc);
    logic signed [63:0] w_bprod;
    always_comb begin
        if (r_state == S_BLEND_A) w_bprod = 64'(w_alpha) * 64'(w_e);
        else w_bprod = 64'(18'sd65536 - w_alpha) * 64'(r_tilt[r_axis]);
    end
    logic signed [47:0] w_bres;
    logic signed [31:0] w_bsat;
    assign w_bres = 48'((r_acc + 64'sd32768) >>> 16);
    always_comb begin
        if (w_bres > 48'sd2147483647)       w_bsat = 32'sh7fffffff;
        else if (w_bres < -48'sd2147483648) w_bsat = 32'sh80000000;
        else                                 w_bsat = w_bres[31:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (s_in.valid) n_state = S_RATE;
            S_RATE:    if (r_rsel == 2'd2) n_state = S_SQ;
            S_SQ:      n_state = r_zero ? S_ROUND : S_SQRT;
            S_SQRT:    if (r_cnt == 6'd32) n_state = S_CORDIC;
            S_CORDIC:  if (32'(r_ci) == CORDIC_STEPS - 1 || 32'(r_ci) == NUM_ATAN - 1)
                           n_state = S_ROUND;
            S_ROUND:   n_state = S_BLEND_A;
            S_BLEND_A: n_state = S_BLEND_B;
            S_BLEND_B: n_state = S_BLEND_C;
            S_BLEND_C: n_state = S_NEXT;
            S_NEXT:    n_state = r_axis ? S_OUT : S_SQ;
            S_OUT:     if (!r_out_valid) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_est_roll  <= '0; r_est_pitch <= '0; r_est_yaw <= '0;
            r_int_roll  <= '0; r_int_pitch <= '0; r_int_yaw <= '0;
        end else begin
            r_state <= n_state;
            if (m_out.ready && r_out_valid) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_in   <= s_in.data;
                    r_rsel <= 2'd0;
                    r_axis <= 1'b0;
                end
                S_RATE: begin
                    r_inc[r_rsel] <= w_rinc[31:0];
                    r_rsel <= r_rsel + 2'd1;
                    r_zero <= (r_axis ? r_in.accel_y : r_in.accel_x) == 16'sd0;
                end
                S_SQ: begin
                    r_sq   <= 64'(36'(w_b) * 36'(w_b) + 36'(w_c) * 36'(w_c)) << 32;
                    r_cnt  <= 6'd0;
                    r_z    <= '0;
                    r_ci   <= '0;
                end
                S_SQRT: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd32) begin
                        r_x <= 52'(r_root);
                        r_y <= 52'(w_num) <<< 16;
                    end
                end
                S_CORDIC: begin
                    if (!r_y[51]) begin
                        r_x <= r_x + w_dx; r_y <= r_y - w_dy;
                        r_z <= r_z + $signed({2'b00, w_atan});
                    end else begin
                        r_x <= r_x - w_dx; r_y <= r_y + w_dy;
                        r_z <= r_z - $signed({2'b00, w_atan});
                    end
                    r_ci <= r_ci + CW'(1);
                end
                S_ROUND: r_tilt[r_axis] <= r_zero ? 24'sd0 : w_zr[23:0];
                S_BLEND_A: r_acc <= w_bprod;
                S_BLEND_B: r_acc <= r_acc + w_bprod;
                S_BLEND_C: begin
                    if (r_axis) r_est_pitch <= w_bsat;
                    else        r_est_roll  <= w_bsat;
                end
                S_NEXT: begin
                    r_axis <= 1'b1;
                    r_zero <= r_in.accel_y == 16'sd0;
                    if (r_axis) begin
                        r_est_yaw   <= r_est_yaw + r_inc[2];
                        r_int_roll  <= r_int_roll + r_inc[1];
                        r_int_pitch <= r_int_pitch + r_inc[0];
                        r_int_yaw   <= r_int_yaw + r_inc[2];
                    end
                end
                S_OUT: if (!r_out_valid) begin
                    r_out_valid <= 1'b1;
                    r_out.accel_roll      <= r_tilt[0];
                    r_out.accel_pitch     <= r_tilt[1];
                    r_out.fused_roll      <= r_est_roll;
                    r_out.fused_pitch     <= r_est_pitch;
                    r_out.fused_yaw       <= r_est_yaw;
                    r_out.gyro_only_roll  <= r_int_roll;
                    r_out.gyro_only_pitch <= r_int_pitch;
                    r_out.gyro_only_yaw   <= r_int_yaw;
                end
                default: ;
            endcase
        end
    end

    // bit-serial square root on its own registers, two radicand bits a cycle
    logic [65:0] r_sr_rem;
    logic [65:0] w_sr_sh, w_sr_try;
    assign w_sr_sh  = {r_sr_rem[63:0], r_sq[63 - 2*r_cnt[4:0] -: 2]};
    assign w_sr_try = {30'd0, r_root, 2'b01};
    always_ff @(posedge i_clk) begin
        if (r_state == S_SQ) begin
            r_sr_rem <= '0;
            r_root   <= '0;
        end else if (r_state == S_SQRT && r_cnt != 6'd32) begin
            if (w_sr_sh >= w_sr_try) begin
                r_sr_rem <= w_sr_sh - w_sr_try;
                r_root   <= {r_root[32:0], 1'b1};
            end else begin
                r_sr_rem <= w_sr_sh;
                r_root   <= {r_root[32:0], 1'b0};
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_out.ready |=> r_out_valid)
        else $error("result dropped while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !s_in.ready)
        else $error("ready while busy");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in.valid && s_in.ready |=> r_state == S_RATE)
        else $error("accepted item not started");

endmodule

[dv/ictf_tb_if.sv]
// Interface: receiver hold flag shared by the test tasks and the stall process.
interface ictf_stall_if;
    timeunit 1ns;
    timeprecision 1ps;
    logic hold;
endinterface

[dv/testbench.sv]
// Testbench for the complementary tilt filter: directed and random accel/gyro items checked against a predictor.
module testbench;
    import ictf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ictf_if #(.T(t_in_item))  in_ch ();
    ictf_if #(.T(t_out_item)) out_ch ();
    ictf_if #(.T(t_cfg_item)) cfg_ch ();
    ictf_stall_if stall_ch ();

    imu_complementary_tilt_filter_core u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .s_in   (in_ch.sink),
        .m_out  (out_ch.source),
        .s_cfg  (cfg_ch.sink)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // predictor state
    longint alpha_q16;
    longint gain_q32;
    logic [31:0] est_roll, est_pitch, est_yaw, int_roll, int_pitch, int_yaw;
    t_out_item angle_queue[$];

    int mismatches = 0;
    int results_seen = 0;
    int items_sent = 0;
    int stall_mode = 0;

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint tilt_angle(longint n, longint b, longint c);
        longint x, y, z, dx, dy, lim;
        if (n == 0) return 0;
        x = int_sqrt(longint'(b * b + c * c) << 32);
        y = n * 65536;
        z = 0;
        for (int i = 0; i < 18; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(ATAN_DEG24[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(ATAN_DEG24[i]);
            end
        end
        if (z > 64'sd1509949440) z = 64'sd1509949440;
        if (z < -64'sd1509949440) z = -64'sd1509949440;
        z = shr_floor(z + 128, 8);
        lim = 64'sd90 << 16;
        if (z > lim) z = lim;
        if (z < -lim) z = -lim;
        return z;
    endfunction

    function automatic longint rate_step(longint r);
        return shr_floor(r * gain_q32 + 32768, 16);
    endfunction

    function automatic logic [31:0] fuse(logic [31:0] est, longint inc, longint tl);
        longint a, e, r;
        a = (alpha_q16 > 65536) ? 65536 : alpha_q16;
        e = longint'(signed'(est)) + inc;
        r = shr_floor(a * e + (65536 - a) * tl + 32768, 16);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic void predict_angles(t_in_item it);
        longint ip, ir, iy, tr, tp;
        t_out_item o;
        ip = rate_step(longint'(it.rate_x));
        ir = rate_step(longint'(it.rate_y));
        iy = rate_step(longint'(it.rate_z));
        tr = tilt_angle(-longint'(it.accel_x), it.accel_y, it.accel_z);
        tp = tilt_angle(longint'(it.accel_y), it.accel_x, it.accel_z);
        est_roll = fuse(est_roll, ir, tr);
        est_pitch = fuse(est_pitch, ip, tp);
        est_yaw += iy[31:0];
        int_roll += ir[31:0];
        int_pitch += ip[31:0];
        int_yaw += iy[31:0];
        o.accel_roll = tr[23:0];
        o.accel_pitch = tp[23:0];
        o.fused_roll = est_roll;
        o.fused_pitch = est_pitch;
        o.fused_yaw = est_yaw;
        o.gyro_only_roll = int_roll;
        o.gyro_only_pitch = int_pitch;
        o.gyro_only_yaw = int_yaw;
        angle_queue.push_back(o);
    endfunction

    // send one item and drop valid afterwards; longer sender gaps come from the callers
    task automatic send_sample(t_in_item it);
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_angles(it);
        items_sent++;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [23:0] val);
        t_cfg_item c;
        c.index = idx;
        c.data = val;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= c;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_BLEND_WEIGHT) alpha_q16 = val & 24'h1FFFF;
        else gain_q32 = val;
        @(posedge i_clk);
    endtask

    task automatic drain();
        int n;
        n = 0;
        while (angle_queue.size() != 0 && n < 200000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (300) @(posedge i_clk);
    endtask

    task automatic idle_gap();
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 40)) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_sample();
        t_in_item it;
        it.accel_x = pick16();
        it.accel_y = pick16();
        it.accel_z = pick16();
        it.rate_x = pick16();
        it.rate_y = pick16();
        it.rate_z = pick16();
        return it;
    endfunction

    task automatic test_directed();
        t_in_item it;
        logic [15:0] ext[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001};
        for (int k = 0; k < 4; k++) begin
            it = '{default: ext[k]};
            send_sample(it);
        end
        // zero numerator over zero denominator
        it = '0; send_sample(it);
        // zero denominators with nonzero numerators; the last item is level with a large roll rate
        it = '0; it.accel_x = 16'sd500; send_sample(it);
        it = '0; it.accel_x = -16'sd500; send_sample(it);
        it = '0; it.accel_y = 16'sd700; send_sample(it);
        it = '0; it.accel_y = 16'sh8000; send_sample(it);
        it = '0; it.accel_z = 16'sd16384; it.rate_y = 16'sd32767; send_sample(it);
        for (int k = 0; k < 8; k++) send_sample(random_sample());
        drain();
    endtask

    task automatic test_settings();
        logic [23:0] aw[5] = '{24'd0, 24'd65536, 24'h1FFFF, 24'd32768, 24'd62915};
        logic [23:0] gw[5] = '{24'hFFFFFF, 24'd0, 24'd1, 24'hFFFFFF, 24'd163930};
        t_in_item it;
        for (int s = 0; s < 5; s++) begin
            write_reg(REG_BLEND_WEIGHT, aw[s]);
            write_reg(REG_RATE_GAIN, gw[s]);
            for (int k = 0; k < 60; k++) begin
                it = random_sample();
                // steady extreme pitch and roll rates at full gain
                if (s == 3) begin
                    it.rate_x = 16'h7FFF;
                    it.rate_y = 16'h8000;
                end
                idle_gap();
                send_sample(it);
            end
            drain();
        end
    endtask

    task automatic test_backpressure();
        stall_ch.hold = 1'b1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                stall_ch.hold = 1'b0;
            end
            for (int k = 0; k < 6; k++) send_sample(random_sample());
        join
        drain();
    endtask

    task automatic test_random();
        int burst;
        while (items_sent < 1700) begin
            burst = $urandom_range(1, 30);
            stall_mode = $urandom_range(0, 3);
            for (int k = 0; k < burst; k++) send_sample(random_sample());
            repeat ($urandom_range(0, 60)) @(posedge i_clk);
            if ($urandom_range(0, 20) == 0) begin
                drain();
                write_reg(REG_BLEND_WEIGHT, 24'($urandom_range(0, 70000)));
                write_reg(REG_RATE_GAIN, 24'($urandom));
            end
        end
        drain();
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n || stall_ch.hold) begin
            out_ch.ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 1) == 0);
                2: out_ch.ready <= ($urandom_range(0, 9) != 0);
                default: out_ch.ready <= ($urandom_range(0, 200) > 150);
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_item exp_o;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (angle_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %p", out_ch.data);
            end else begin
                exp_o = angle_queue.pop_front();
                if (exp_o !== out_ch.data) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch item %0d\n  exp %p\n  got %p",
                            results_seen, exp_o, out_ch.data);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        stall_ch.hold = 1'b0;
        alpha_q16 = 62915;
        gain_q32 = 163930;
        {est_roll, est_pitch, est_yaw, int_roll, int_pitch, int_yaw} = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_settings();
        test_backpressure();
        test_random();
        if (angle_queue.size() != 0) mismatches += angle_queue.size();
        $display("Covered %0d samples, %0d results, across several blend and gain settings",
            items_sent, results_seen);
        $display("with long receiver holds and random sender gaps");
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
